FILE: src/pcl_pkg.sv
// Shared types and codes for the positional circular list unit.
package pcl_pkg;

	// Default sizes
	localparam int unsigned DEF_CAPACITY   = 32;
	localparam int unsigned DEF_DATA_WIDTH = 32;

	// Fixed port widths
	localparam int unsigned REQ_W   = 3;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 6;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned CNT_W   = 6;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DEL_POS   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd4;
	localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 3'd5;
	localparam logic [REQ_W-1:0] REQ_DUMP      = 3'd6;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

	// Row-wide shift operation broadcast by the controller
	typedef enum logic [1:0] {
		SH_NONE,
		SH_INS,
		SH_DEL,
		SH_ROT
	} shift_op_t;

	// Per-cell load select
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LEFT,
		CELL_RIGHT,
		CELL_LOAD
	} cell_cmd_t;

	// Controller state
	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

endpackage

FILE: src/pcl_cell.sv
// One list cell: holds a single element and loads from a neighbor or new data.
module pcl_cell #(
	parameter int unsigned DATA_WIDTH = pcl_pkg::DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  pcl_pkg::cell_cmd_t    cmd,
	input  logic [DATA_WIDTH-1:0] left_d,
	input  logic [DATA_WIDTH-1:0] right_d,
	input  logic [DATA_WIDTH-1:0] load_d,
	output logic [DATA_WIDTH-1:0] q
);
	import pcl_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;

	// element register
	always_ff @(posedge clk) begin
		case (cmd)
			CELL_LEFT:  data_q <= left_d;
			CELL_RIGHT: data_q <= right_d;
			CELL_LOAD:  data_q <= load_d;
			default:    data_q <= data_q;
		endcase
	end

	assign q = data_q;

endmodule

FILE: src/pcl_ctrl.sv
// Request decoder, live count, dump sequencer and output word register.
module pcl_ctrl #(
	parameter int unsigned CAPACITY   = pcl_pkg::DEF_CAPACITY,
	parameter int unsigned DATA_WIDTH = pcl_pkg::DEF_DATA_WIDTH,
	parameter int unsigned CW         = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [pcl_pkg::REQ_W-1:0]    req_type,
	input  logic [pcl_pkg::VALUE_W-1:0]  value,
	input  logic [pcl_pkg::POS_W-1:0]    position,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pcl_pkg::STAT_W-1:0]   status,
	output logic [pcl_pkg::VALUE_W-1:0]  item_value,
	output logic [pcl_pkg::POS_W-1:0]    item_index,
	output logic [pcl_pkg::CNT_W-1:0]    element_count,
	output logic                         last,
	input  logic [DATA_WIDTH-1:0]        head,
	output pcl_pkg::shift_op_t           op,
	output logic [CW-1:0]                slot,
	output logic [DATA_WIDTH-1:0]        load_d
);
	import pcl_pkg::*;

	// compare width: holds count+1 and any position
	localparam int unsigned CMPW = (CW > POS_W) ? CW + 1 : POS_W + 1;

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]   idx_q, idx_d;

	logic            out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [VALUE_W-1:0] value_q;
	logic [POS_W-1:0]   index_q;
	logic [CNT_W-1:0]   count_q;
	logic               last_q;

	logic            out_free;
	logic            accept;
	logic            emit;
	logic [STAT_W-1:0]  r_status;
	logic [VALUE_W-1:0] r_value;
	logic [POS_W-1:0]   r_index;
	logic               r_last;

	logic [CMPW-1:0] posw;
	logic [CMPW-1:0] cntw;
	logic            full;
	logic            empty;
	logic            ins_bad;
	logic            del_bad;
	logic [CW-1:0]   idx_inc;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;

	assign posw    = CMPW'(position);
	assign cntw    = CMPW'(cnt_q);
	assign full    = (cnt_q == CW'(CAPACITY));
	assign empty   = (cnt_q == '0);
	assign ins_bad = (posw == '0) || (posw > cntw + CMPW'(1));
	assign del_bad = (posw == '0) || (posw > cntw);
	assign idx_inc = idx_q + CW'(1);

	// next state, row operation and result word
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		emit     = 1'b0;
		r_status = STAT_OK;
		r_value  = '0;
		r_index  = '0;
		r_last   = 1'b1;
		op       = SH_NONE;
		slot     = '0;
		load_d   = DATA_WIDTH'(value);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					emit = 1'b1;
					case (req_type)
						REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
							if (full) begin
								r_status = STAT_FULL;
							end else if (req_type == REQ_INS_POS && ins_bad) begin
								r_status = STAT_BADPOS;
							end else begin
								op    = SH_INS;
								cnt_d = cnt_q + CW'(1);
								if (req_type == REQ_INS_FRONT)
									slot = '0;
								else if (req_type == REQ_INS_BACK)
									slot = cnt_q;
								else
									slot = CW'(posw - CMPW'(1));
							end
						end
						REQ_DEL_POS, REQ_DEL_FRONT, REQ_DEL_BACK: begin
							if (empty) begin
								r_status = STAT_EMPTY;
							end else if (req_type == REQ_DEL_POS && del_bad) begin
								r_status = STAT_BADPOS;
							end else begin
								op    = SH_DEL;
								cnt_d = cnt_q - CW'(1);
								if (req_type == REQ_DEL_FRONT)
									slot = '0;
								else if (req_type == REQ_DEL_BACK)
									slot = cnt_q - CW'(1);
								else
									slot = CW'(posw - CMPW'(1));
							end
						end
						REQ_DUMP: begin
							if (empty) begin
								r_status = STAT_EMPTY;
							end else begin
								// elements stream out of the head cell from next cycle
								emit    = 1'b0;
								idx_d   = '0;
								state_d = ST_DUMP;
							end
						end
						default: r_status = STAT_BADPOS;
					endcase
				end
			end
			ST_DUMP: begin
				if (out_free) begin
					// take head word, rotate live part of the row by one
					emit    = 1'b1;
					r_value = VALUE_W'(head);
					r_index = POS_W'(idx_inc);
					r_last  = (idx_inc == cnt_q);
					op      = SH_ROT;
					slot    = cnt_q - CW'(1);
					load_d  = head;
					idx_d   = idx_inc;
					if (r_last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			if (out_free)
				out_valid_q <= emit;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= r_status;
			value_q  <= r_value;
			index_q  <= r_index;
			count_q  <= CNT_W'(cnt_d);
			last_q   <= r_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign item_value    = value_q;
	assign item_index    = index_q;
	assign element_count = count_q;
	assign last          = last_q;

endmodule

FILE: src/positional_circular_list_unit.sv
// Top level of the positional circular list unit: row of element cells plus controller.
//
//  channel   direction  handshake            fields
//  request   in         in_valid/in_stall    req_type, value, position
//  result    out        out_valid/out_stall  status, item_value, item_index,
//                                            element_count, last
//
// Insert, delete and bad requests: the whole cell row shifts at once and the single
// result word is registered; a new request may follow next cycle unless the result
// is stalled. A dump of N elements: the request is taken, then one word per cycle
// while the result is not stalled, as the row rotates through its head cell; requests
// are held off until the last word is produced. An empty dump ends like an update.
// Reset clears the count and handshake state; cell contents are not reset.
// A stalled result word holds the request side and any dump in progress.
module positional_circular_list_unit #(
	parameter int unsigned CAPACITY   = pcl_pkg::DEF_CAPACITY,
	parameter int unsigned DATA_WIDTH = pcl_pkg::DEF_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [pcl_pkg::REQ_W-1:0]    req_type,
	input  logic [pcl_pkg::VALUE_W-1:0]  value,
	input  logic [pcl_pkg::POS_W-1:0]    position,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pcl_pkg::STAT_W-1:0]   status,
	output logic [pcl_pkg::VALUE_W-1:0]  item_value,
	output logic [pcl_pkg::POS_W-1:0]    item_index,
	output logic [pcl_pkg::CNT_W-1:0]    element_count,
	output logic                         last
);
	import pcl_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	shift_op_t             op;
	logic [CW-1:0]         slot;
	logic [DATA_WIDTH-1:0] load_d;
	logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

	pcl_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH),
		.CW         (CW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.value         (value),
		.position      (position),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.item_value    (item_value),
		.item_index    (item_index),
		.element_count (element_count),
		.last          (last),
		.head          (cell_q[0]),
		.op            (op),
		.slot          (slot),
		.load_d        (load_d)
	);

	// cell row: element 1 in cell 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_cmd_t             cmd;
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = load_d;
		end else begin : g_left
			assign left_d = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign right_d = cell_q[i];
		end else begin : g_right
			assign right_d = cell_q[i+1];
		end

		// local decode of the broadcast operation
		always_comb begin
			cmd = CELL_HOLD;
			case (op)
				SH_INS: begin
					if (CW'(i) > slot)
						cmd = CELL_LEFT;
					else if (CW'(i) == slot)
						cmd = CELL_LOAD;
				end
				SH_DEL: begin
					if (CW'(i) >= slot && i != CAPACITY - 1)
						cmd = CELL_RIGHT;
				end
				SH_ROT: begin
					if (CW'(i) < slot)
						cmd = CELL_RIGHT;
					else if (CW'(i) == slot)
						cmd = CELL_LOAD;
				end
				default: cmd = CELL_HOLD;
			endcase
		end

		pcl_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.left_d  (left_d),
			.right_d (right_d),
			.load_d  (load_d),
			.q       (cell_q[i])
		);
	end

endmodule
